FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL of the sign-magnitude hex ALU core.
// Each expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define SMH_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define SMH_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/smhalu_pkg.sv
// Shared constants for the sign-magnitude hex ALU: operation codes,
// compare codes and the default operand size. No dependencies.
`timescale 1ns / 1ps

package smhalu_pkg;

	localparam int NUM_BYTES_DEF = 8;

	localparam logic [2:0] FUNC_ADD = 3'd0;
	localparam logic [2:0] FUNC_SUB = 3'd1;
	localparam logic [2:0] FUNC_SHL = 3'd2;
	localparam logic [2:0] FUNC_SHR = 3'd3;
	localparam logic [2:0] FUNC_CMP = 3'd4;

	localparam logic signed [1:0] CMP_EQ = 2'sb00;
	localparam logic signed [1:0] CMP_GT = 2'sb01;
	localparam logic signed [1:0] CMP_LT = 2'sb11;

	localparam int FIELD_W = 64;
	localparam int LEN_W   = 5;

endpackage

FILE: rtl/smhalu_encode.sv
// Sign-magnitude encoder: packs a sign and magnitude into the shortest digit
// length whose top bit can carry the sign. Takes its default size from smhalu_pkg.
`timescale 1ns / 1ps

module smhalu_encode #(
	parameter int DIGITS = 2 * smhalu_pkg::NUM_BYTES_DEF
) (
	input  logic                         neg,
	input  logic [4*DIGITS-1:0]          mag,
	output logic [4*DIGITS-1:0]          val,
	output logic [$clog2(DIGITS+1)-1:0]  len,
	output logic                         ovf
);

	localparam int LW = $clog2(DIGITS + 1);

	logic [LW-1:0] k;
	logic          top;
	logic [LW-1:0] n;

	always_comb begin
		k   = '0;
		top = 1'b0;
		// highest nonzero digit sets the raw length
		for (int i = 0; i < DIGITS; i++) begin
			if (mag[4*i +: 4] != 4'h0) begin
				k   = LW'(i + 1);
				top = mag[4*i+3];
			end
		end
		n = k + LW'(top);
		val = '0;
		len = LW'(1);
		ovf = 1'b0;
		if (k == '0) begin
			val = '0;
			len = LW'(1);
		end else if (k == LW'(DIGITS) && top) begin
			ovf = 1'b1;
		end else begin
			val = mag;
			len = n;
			for (int i = 0; i < DIGITS; i++) begin
				if (LW'(i + 1) == n) begin
					val[4*i+3] = neg;
				end
			end
		end
	end

endmodule

FILE: rtl/sign_magnitude_hex_alu_core.sv
// Three register stages; throughput one item per cycle while in_stall is low.
// Stage 1 splits and compares operands, stage 2 adds or shifts, stage 3 encodes.
// A stall on the output backs up stage by stage; empty stages still fill.
// Reset (arst_n low) empties the pipeline; payload registers are not reset.
// Depends on smhalu_pkg, smhalu_encode and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sign_magnitude_hex_alu_core #(
	parameter int NUM_BYTES = smhalu_pkg::NUM_BYTES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [2:0]                           func,
	input  logic [smhalu_pkg::FIELD_W-1:0]       operand_a,
	input  logic [smhalu_pkg::LEN_W-1:0]         length_a,
	input  logic [smhalu_pkg::FIELD_W-1:0]       operand_b,
	input  logic [smhalu_pkg::LEN_W-1:0]         length_b,
	input  logic [smhalu_pkg::LEN_W-1:0]         shift_digits,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [smhalu_pkg::FIELD_W-1:0]       result_value,
	output logic [smhalu_pkg::LEN_W-1:0]         result_length,
	output logic signed [1:0]                    compare_result,
	output logic                                 overflow
);

	localparam int D  = 2 * NUM_BYTES;
	localparam int W  = 4 * D;
	localparam int LW = $clog2(D + 1);
	localparam int SW = $clog2(D);

	// pipeline control
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	assign en3 = !v_s3 || !out_stall;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// ---------------- stage 1: clamp, split, compare ----------------
	logic [LW-1:0] la_c, lb_c;
	logic          na_c, nb_c;
	logic [W-1:0]  ma_c, mb_c;

	always_comb begin
		if (length_a == '0)                  la_c = LW'(1);
		else if (length_a > 5'(D))           la_c = LW'(D);
		else                                 la_c = length_a[LW-1:0];
		if (length_b == '0)                  lb_c = LW'(1);
		else if (length_b > 5'(D))           lb_c = LW'(D);
		else                                 lb_c = length_b[LW-1:0];

		na_c = 1'b0;
		nb_c = 1'b0;
		ma_c = '0;
		mb_c = '0;
		// keep digits below the length, pull the sign out of the leftmost one
		for (int i = 0; i < D; i++) begin
			if (LW'(i) < la_c) ma_c[4*i +: 4] = operand_a[4*i +: 4];
			if (LW'(i) < lb_c) mb_c[4*i +: 4] = operand_b[4*i +: 4];
			if (LW'(i + 1) == la_c) begin
				na_c = operand_a[4*i+3];
				ma_c[4*i+3] = 1'b0;
			end
			if (LW'(i + 1) == lb_c) begin
				nb_c = operand_b[4*i+3];
				mb_c[4*i+3] = 1'b0;
			end
		end
	end

	logic [2:0]    func_s1;
	logic          na_s1, nb_s1;
	logic [W-2:0]  ma_s1, mb_s1;
	logic [LW-1:0] la_s1;
	logic [SW-1:0] sh_s1;
	logic          sh_ok_s1, ge_s1, eq_s1, zero_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			func_s1  <= func;
			na_s1    <= na_c;
			nb_s1    <= nb_c;
			ma_s1    <= ma_c[W-2:0];
			mb_s1    <= mb_c[W-2:0];
			la_s1    <= la_c;
			sh_s1    <= shift_digits[SW-1:0];
			sh_ok_s1 <= shift_digits < 5'(la_c);
			ge_s1    <= ma_c >= mb_c;
			eq_s1    <= ma_c == mb_c;
			zero_s1  <= (ma_c == '0) && (mb_c == '0);
		end
	end

	// ---------------- stage 2: add/subtract, shift, compare ----------------
	logic          nb_eff, same, x_sel;
	logic [W-1:0]  opx, opy, sum_c, shl_c, shr_c, shv_c;
	logic          rneg_c;
	logic [W-1:0]  val2_c;
	logic [LW-1:0] len2_c;
	logic          enc2_c;
	logic signed [1:0] cmp2_c;

	always_comb begin
		nb_eff = nb_s1 ^ (func_s1 == smhalu_pkg::FUNC_SUB);
		same   = na_s1 == nb_eff;
		x_sel  = ge_s1;
		opx    = x_sel ? {1'b0, ma_s1} : {1'b0, mb_s1};
		opy    = x_sel ? {1'b0, mb_s1} : {1'b0, ma_s1};
		// one adder: plain sum for like signs, larger minus smaller otherwise
		if (same) sum_c = {1'b0, ma_s1} + {1'b0, mb_s1};
		else      sum_c = opx + ~opy + W'(1);
		rneg_c = same ? na_s1 : (ge_s1 ? na_s1 : nb_eff);

		shl_c = {1'b0, ma_s1} << {sh_s1, 2'b00};
		shr_c = {1'b0, ma_s1} >> {sh_s1, 2'b00};
		shv_c = '0;
		if (sh_ok_s1) shv_c = (func_s1 == smhalu_pkg::FUNC_SHL) ? shl_c : shr_c;
		for (int i = 0; i < D; i++) begin
			if (!(LW'(i) < la_s1)) shv_c[4*i +: 4] = 4'h0;
			if (LW'(i + 1) == la_s1) shv_c[4*i+3] = na_s1;
		end

		val2_c = '0;
		len2_c = LW'(1);
		enc2_c = 1'b0;
		cmp2_c = smhalu_pkg::CMP_EQ;
		unique case (func_s1)
			smhalu_pkg::FUNC_ADD, smhalu_pkg::FUNC_SUB: begin
				val2_c = sum_c;
				enc2_c = 1'b1;
			end
			smhalu_pkg::FUNC_SHL, smhalu_pkg::FUNC_SHR: begin
				val2_c = shv_c;
				len2_c = la_s1;
			end
			smhalu_pkg::FUNC_CMP: begin
				priority if (zero_s1)         cmp2_c = smhalu_pkg::CMP_EQ;
				else if (!na_s1 && nb_s1)     cmp2_c = smhalu_pkg::CMP_GT;
				else if (na_s1 && !nb_s1)     cmp2_c = smhalu_pkg::CMP_LT;
				else if (eq_s1)               cmp2_c = smhalu_pkg::CMP_EQ;
				else if (ge_s1)
					cmp2_c = na_s1 ? smhalu_pkg::CMP_LT : smhalu_pkg::CMP_GT;
				else
					cmp2_c = na_s1 ? smhalu_pkg::CMP_GT : smhalu_pkg::CMP_LT;
			end
			default: begin
				val2_c = '0;
			end
		endcase
	end

	logic [W-1:0]      val_s2;
	logic [LW-1:0]     len_s2;
	logic              neg_s2, enc_s2;
	logic signed [1:0] cmp_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			val_s2 <= val2_c;
			len_s2 <= len2_c;
			neg_s2 <= rneg_c;
			enc_s2 <= enc2_c;
			cmp_s2 <= cmp2_c;
		end
	end

	// ---------------- stage 3: shortest-length encode ----------------
	logic [W-1:0]  enc_val;
	logic [LW-1:0] enc_len;
	logic          enc_ovf;

	smhalu_encode #(
		.DIGITS (D)
	) u_encode (
		.neg (neg_s2),
		.mag (val_s2),
		.val (enc_val),
		.len (enc_len),
		.ovf (enc_ovf)
	);

	logic [W-1:0]      val_s3;
	logic [LW-1:0]     len_s3;
	logic signed [1:0] cmp_s3;
	logic              ovf_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			val_s3 <= enc_s2 ? enc_val : val_s2;
			len_s3 <= enc_s2 ? enc_len : len_s2;
			ovf_s3 <= enc_s2 && enc_ovf;
			cmp_s3 <= cmp_s2;
		end
	end

	assign out_valid      = v_s3;
	assign result_value   = smhalu_pkg::FIELD_W'(val_s3);
	assign result_length  = smhalu_pkg::LEN_W'(len_s3);
	assign compare_result = cmp_s3;
	assign overflow       = ovf_s3;

	// ---------------- checks ----------------
	`SMH_ASSERT(a_ovf_zero, clk, arst_n, v_s3 && ovf_s3 |-> val_s3 == '0 && len_s3 == LW'(1), "overflow result must be zero with length one")
	`SMH_NEVER(a_cmp_code, clk, arst_n, v_s3 && cmp_s3 == 2'sb10, "illegal compare code")
	`SMH_NEVER(a_len_zero, clk, arst_n, v_s3 && len_s3 == '0, "result length of zero")
	`SMH_ASSERT(a_empty_no_stall, clk, arst_n, !v_s1 |-> !in_stall, "empty first stage refused a transfer")

endmodule

FILE: tb/tb.sv
// Self-checking testbench for sign_magnitude_hex_alu_core: directed table, then random traffic.
// Scores each result against an in-file predictor of the sign-magnitude ALU.
// Depends on smhalu_pkg and the RTL of the core.
`timescale 1ns / 1ps

module tb;

	localparam int DIGITS = 2 * smhalu_pkg::NUM_BYTES_DEF;
	localparam int FW = smhalu_pkg::FIELD_W;
	localparam int LW = smhalu_pkg::LEN_W;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;
	localparam int MAX_REPORTS = 10;
	localparam int RANDOM_PER_PHASE = 150;
	localparam logic [2:0] FUNC_RSV_LO = 3'd5;
	localparam logic [2:0] FUNC_RSV_HI = 3'd7;

	typedef struct packed {
		logic [FW-1:0] value;
		logic [LW-1:0] len;
		logic [1:0]    cmp;
		logic          ovf;
	} alu_result_t;

	typedef struct packed {
		logic [2:0]    op;
		logic [FW-1:0] a;
		logic [LW-1:0] la;
		logic [FW-1:0] b;
		logic [LW-1:0] lb;
		logic [LW-1:0] sh;
		bit            has_want;
		alu_result_t   want;
	} stim_row_t;

	localparam alu_result_t ZERO_RESULT = '{64'h0, 5'd1, smhalu_pkg::CMP_EQ, 1'b0};
	localparam alu_result_t OVF_RESULT  = '{64'h0, 5'd1, smhalu_pkg::CMP_EQ, 1'b1};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [2:0]           func = smhalu_pkg::FUNC_ADD;
	logic [FW-1:0]        operand_a = '0;
	logic [LW-1:0]        length_a = 5'd1;
	logic [FW-1:0]        operand_b = '0;
	logic [LW-1:0]        length_b = 5'd1;
	logic [LW-1:0]        shift_digits = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [FW-1:0]        result_value;
	logic [LW-1:0]        result_length;
	logic signed [1:0]    compare_result;
	logic                 overflow;

	alu_result_t pending_alu_results[$];
	stim_row_t   directed_rows[$];
	int          send_idle_pct = 14;
	int          recv_stall_pct = 74;
	int          mismatch_count = 0;
	int          items_sent = 0;
	int          results_checked = 0;
	int          overflow_seen = 0;
	int          quiet_cycles = 0;

	sign_magnitude_hex_alu_core #(
		.NUM_BYTES(smhalu_pkg::NUM_BYTES_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.operand_a(operand_a),
		.length_a(length_a),
		.operand_b(operand_b),
		.length_b(length_b),
		.shift_digits(shift_digits),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_value(result_value),
		.result_length(result_length),
		.compare_result(compare_result),
		.overflow(overflow)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [63:0] field_mask(input int unsigned bits);
		if (bits >= 64)
			return '1;
		return (64'd1 << bits) - 64'd1;
	endfunction

	// Length 0 reads as one digit, anything past the width as the full width.
	function automatic int unsigned digit_count(input logic [LW-1:0] l);
		if (l == 0)
			return 1;
		if (l > DIGITS)
			return DIGITS;
		return 32'(l);
	endfunction

	function automatic void split_operand(input logic [63:0] v, input int unsigned len,
			output logic neg, output logic [63:0] mag);
		logic [63:0] digits;
		digits = v & field_mask(4 * len);
		neg = digits[4 * len - 1];
		mag = digits & field_mask(4 * len - 1);
	endfunction

	function automatic alu_result_t predict_alu(input logic [2:0] op, input logic [63:0] a,
			input logic [LW-1:0] la_raw, input logic [63:0] b,
			input logic [LW-1:0] lb_raw, input logic [LW-1:0] sh);
		alu_result_t r;
		int unsigned la, lb, k, n;
		logic na, nb, rneg;
		logic [63:0] ma, mb, rmag, m;
		r = ZERO_RESULT;
		la = digit_count(la_raw);
		lb = digit_count(lb_raw);
		split_operand(a, la, na, ma);
		split_operand(b, lb, nb, mb);
		unique case (op)
			smhalu_pkg::FUNC_ADD, smhalu_pkg::FUNC_SUB: begin
				if (op == smhalu_pkg::FUNC_SUB)
					nb = !nb;
				if (na == nb) begin
					rneg = na;
					rmag = ma + mb;
				end else if (ma >= mb) begin
					rneg = na;
					rmag = ma - mb;
				end else begin
					rneg = nb;
					rmag = mb - ma;
				end
				if (rmag != 0) begin
					k = 0;
					for (int i = 0; i < 16; i++)
						if (rmag[4 * i +: 4] != 0)
							k = i + 1;
					// a set top bit would read as a sign: widen by one digit
					n = rmag[4 * k - 1] ? k + 1 : k;
					if (n > DIGITS) begin
						r.ovf = 1'b1;
					end else begin
						r.value = rmag;
						if (rneg)
							r.value[4 * n - 1] = 1'b1;
						r.len = LW'(n);
					end
				end
			end
			smhalu_pkg::FUNC_SHL, smhalu_pkg::FUNC_SHR: begin
				m = '0;
				if (sh < la)
					m = (op == smhalu_pkg::FUNC_SHL) ? (ma << (4 * sh)) : (ma >> (4 * sh));
				m &= field_mask(4 * la - 1);
				r.value = m;
				if (na)
					r.value[4 * la - 1] = 1'b1;
				r.len = LW'(la);
			end
			smhalu_pkg::FUNC_CMP: begin
				if (ma == 0 && mb == 0)
					r.cmp = smhalu_pkg::CMP_EQ;
				else if (!na && nb)
					r.cmp = smhalu_pkg::CMP_GT;
				else if (na && !nb)
					r.cmp = smhalu_pkg::CMP_LT;
				else if (ma == mb)
					r.cmp = smhalu_pkg::CMP_EQ;
				else if (ma > mb)
					r.cmp = na ? smhalu_pkg::CMP_LT : smhalu_pkg::CMP_GT;
				else
					r.cmp = na ? smhalu_pkg::CMP_GT : smhalu_pkg::CMP_LT;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic logic [63:0] random_operand(input logic [LW-1:0] len_raw);
		int unsigned len, kind;
		logic [63:0] v, junk;
		len = digit_count(len_raw);
		junk = {$urandom, $urandom} & ~field_mask(4 * len);
		kind = $urandom_range(7);
		unique case (kind)
			0: v = '0;
			1: v = field_mask(4 * len - 1);
			2: v = 64'($urandom_range(15));
			default: v = {$urandom, $urandom};
		endcase
		if (kind < 3) begin
			v &= field_mask(4 * len - 1);
			v[4 * len - 1] = 1'($urandom_range(1));
			if ($urandom_range(1))
				v |= junk;
		end
		return v;
	endfunction

	function automatic stim_row_t random_row();
		stim_row_t r;
		r = '0;
		if ($urandom_range(99) < 6)
			r.op = 3'($urandom_range(FUNC_RSV_HI, FUNC_RSV_LO));
		else
			r.op = 3'($urandom_range(smhalu_pkg::FUNC_CMP, smhalu_pkg::FUNC_ADD));
		r.la = ($urandom_range(99) < 8) ? LW'($urandom_range(31, 0)) :
			LW'($urandom_range(DIGITS, 1));
		r.a = random_operand(r.la);
		if ($urandom_range(99) < 12) begin
			// same magnitude on both sides, sign kept or flipped
			r.lb = r.la;
			r.b = r.a;
			if ($urandom_range(1))
				r.b[4 * digit_count(r.lb) - 1] = !r.b[4 * digit_count(r.lb) - 1];
		end else begin
			r.lb = ($urandom_range(99) < 8) ? LW'($urandom_range(31, 0)) :
				LW'($urandom_range(DIGITS, 1));
			r.b = random_operand(r.lb);
		end
		r.sh = ($urandom_range(99) < 85) ? LW'($urandom_range(DIGITS, 0)) :
			LW'($urandom_range(31, 0));
		return r;
	endfunction

	task automatic add_row(input logic [2:0] op, input logic [63:0] a,
			input logic [LW-1:0] la, input logic [63:0] b, input logic [LW-1:0] lb,
			input logic [LW-1:0] sh, input bit has_want, input alu_result_t want);
		directed_rows.push_back('{op, a, la, b, lb, sh, has_want, want});
	endtask

	task automatic send_item(input stim_row_t row);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= row.op;
		operand_a <= row.a;
		length_a <= row.la;
		operand_b <= row.b;
		length_b <= row.lb;
		shift_digits <= row.sh;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_alu_results.push_back(row.has_want ? row.want :
			predict_alu(row.op, row.a, row.la, row.b, row.lb, row.sh));
		items_sent++;
	endtask

	task automatic report_mismatch(input string what, input alu_result_t want,
			input alu_result_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t %s: expected value=%h len=%0d cmp=%0d ovf=%b,",
				$time, what, want.value, want.len, $signed(want.cmp), want.ovf,
				" got value=%h len=%0d cmp=%0d ovf=%b",
				got.value, got.len, $signed(got.cmp), got.ovf);
	endtask

	// Score results, drive the output stall, and watch for a hung pipeline.
	always @(posedge clk) begin : result_monitor
		alu_result_t got, want;
		logic in_xfer, out_xfer;
		if (arst_n) begin
			in_xfer = in_valid && !in_stall;
			out_xfer = out_valid && !out_stall;
			if (out_xfer) begin
				got = '{result_value, result_length, compare_result, overflow};
				results_checked++;
				if (overflow)
					overflow_seen++;
				if (pending_alu_results.size() == 0) begin
					report_mismatch("result with nothing pending", ZERO_RESULT, got);
				end else begin
					want = pending_alu_results.pop_front();
					if (got.value !== want.value || got.len !== want.len ||
							got.cmp !== want.cmp || got.ovf !== want.ovf)
						report_mismatch("result mismatch", want, got);
				end
			end
			if (in_xfer || out_xfer)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles, %0d results pending",
					WATCHDOG_LIMIT, pending_alu_results.size());
				$display("Regression FAIL");
				$finish;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	initial begin : stimulus
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		add_row(smhalu_pkg::FUNC_ADD, 64'h0, 5'd1, 64'h0, 5'd1, 5'd0, 1, ZERO_RESULT);
		add_row(smhalu_pkg::FUNC_ADD, 64'h7fff_ffff_ffff_ffff, 5'd16,
			64'h7fff_ffff_ffff_ffff, 5'd16, 5'd0, 1, OVF_RESULT);
		add_row(smhalu_pkg::FUNC_SUB, 64'h7fff_ffff_ffff_ffff, 5'd16,
			64'h8000_0000_0000_0001, 5'd16, 5'd0, 1, OVF_RESULT);
		add_row(smhalu_pkg::FUNC_ADD, 64'h7, 5'd1, 64'h1, 5'd1, 5'd0, 1,
			'{64'h08, 5'd2, smhalu_pkg::CMP_EQ, 1'b0});
		add_row(smhalu_pkg::FUNC_ADD, 64'h9, 5'd1, 64'ha, 5'd1, 5'd0, 1,
			'{64'hb, 5'd1, smhalu_pkg::CMP_EQ, 1'b0});
		// negative zero minus zero
		add_row(smhalu_pkg::FUNC_SUB, 64'h8, 5'd1, 64'h0, 5'd1, 5'd0, 1, ZERO_RESULT);
		add_row(smhalu_pkg::FUNC_SUB, 64'h5, 5'd1, 64'h5, 5'd1, 5'd0, 1, ZERO_RESULT);
		add_row(smhalu_pkg::FUNC_SUB, 64'h1, 5'd1, 64'h9, 5'd1, 5'd0, 1,
			'{64'h2, 5'd1, smhalu_pkg::CMP_EQ, 1'b0});
		add_row(smhalu_pkg::FUNC_SUB, 64'h8000_0000_0000_0005, 5'd16, 64'h3, 5'd1, 5'd0,
			0, ZERO_RESULT);
		// digits above the length are ignored
		add_row(smhalu_pkg::FUNC_ADD, 64'hfff3, 5'd1, 64'habc4, 5'd1, 5'd0, 1,
			'{64'h7, 5'd1, smhalu_pkg::CMP_EQ, 1'b0});
		add_row(smhalu_pkg::FUNC_ADD, 64'h1, 5'd31, 64'h2, 5'd20, 5'd0, 0, ZERO_RESULT);
		// shift by the full length clears the magnitude, keeps the sign
		add_row(smhalu_pkg::FUNC_SHL, 64'h9, 5'd1, 64'h0, 5'd1, 5'd1, 1,
			'{64'h8, 5'd1, smhalu_pkg::CMP_EQ, 1'b0});
		add_row(smhalu_pkg::FUNC_SHR, 64'hf, 5'd1, 64'h0, 5'd1, 5'd0, 1,
			'{64'hf, 5'd1, smhalu_pkg::CMP_EQ, 1'b0});
		add_row(smhalu_pkg::FUNC_SHR, 64'h7654, 5'd4, 64'h0, 5'd1, 5'd2, 0, ZERO_RESULT);
		add_row(smhalu_pkg::FUNC_SHL, 64'h8_1234, 5'd5, 64'h0, 5'd1, 5'd1, 0, ZERO_RESULT);
		add_row(smhalu_pkg::FUNC_SHL, '1, 5'd16, '1, 5'd16, 5'd15, 0, ZERO_RESULT);
		add_row(smhalu_pkg::FUNC_SHR, '1, 5'd0, '1, 5'd0, 5'd31, 0, ZERO_RESULT);
		add_row(smhalu_pkg::FUNC_CMP, 64'h0, 5'd1, 64'h8, 5'd1, 5'd0, 1, ZERO_RESULT);
		add_row(smhalu_pkg::FUNC_CMP, 64'h1, 5'd1, 64'h2, 5'd1, 5'd0, 1,
			'{64'h0, 5'd1, smhalu_pkg::CMP_LT, 1'b0});
		add_row(smhalu_pkg::FUNC_CMP, 64'hb, 5'd1, 64'hd, 5'd1, 5'd0, 1,
			'{64'h0, 5'd1, smhalu_pkg::CMP_GT, 1'b0});
		add_row(smhalu_pkg::FUNC_CMP, 64'h1, 5'd1, 64'h9, 5'd1, 5'd0, 1,
			'{64'h0, 5'd1, smhalu_pkg::CMP_GT, 1'b0});
		add_row(smhalu_pkg::FUNC_CMP, 64'h7fff_ffff_ffff_ffff, 5'd16,
			64'h7fff_ffff_ffff_ffff, 5'd16, 5'd16, 1, ZERO_RESULT);
		add_row(FUNC_RSV_LO, '1, 5'd16, '1, 5'd16, 5'd3, 1, ZERO_RESULT);
		add_row(FUNC_RSV_LO + 3'd1, 64'h1234, 5'd4, 64'h5, 5'd2, 5'd1, 1, ZERO_RESULT);
		add_row(FUNC_RSV_HI, 64'h8, 5'd1, 64'h7, 5'd1, 5'd0, 1, ZERO_RESULT);

		foreach (directed_rows[i])
			send_item(directed_rows[i]);

		for (int phase = 0; phase < 3; phase++) begin
			unique case (phase)
				0: begin send_idle_pct = 14; recv_stall_pct = 74; end
				1: begin send_idle_pct = 74; recv_stall_pct = 14; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			repeat (phase == 0 ? RANDOM_PER_PHASE - directed_rows.size() : RANDOM_PER_PHASE)
				send_item(random_row());
		end
		in_valid <= 1'b0;

		while (pending_alu_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d operations (%0d from the directed table) under three idle/stall mixes",
			items_sent, directed_rows.size());
		$display("Checked %0d results, %0d with overflow, %0d mismatches",
			results_checked, overflow_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
